@@ sv/lits_pkg.sv @@
package lits_pkg;

  localparam int MAX_RANGES = 16;
  localparam int LINE_BITS  = 32;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int RAM_DEPTH  = 4 * MAX_RANGES;
  localparam int RAM_W      = 2 * LINE_BITS;

  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam line_t LINE_MAX    = '1;
  localparam cnt_t  CNT_MAX     = cnt_t'(MAX_RANGES);
  localparam logic  TBL_VALID   = 1'b0;
  localparam logic  TBL_INVALID = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD_VALID   = 3'd0,
    OP_ADD_INVALID = 3'd1,
    OP_INVALIDATE  = 3'd2,
    OP_QUERY       = 3'd3,
    OP_CLR_VALID   = 3'd4,
    OP_CLR_INVALID = 3'd5,
    OP_CLR_ALL     = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    PASS_INS,
    PASS_CUT,
    PASS_QRY
  } pass_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_EVAL,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic eval;
    logic finish;
    logic emit_out;
  } cmd_t;

  typedef struct packed {
    logic pass_none;
    logic walk_end;
    logic eval_stay;
    logic eval_stop;
    logic next_pass;
    logic out_free;
  } status_t;

endpackage

@@ sv/lits_ram.sv @@
module lits_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lits_ctrl.sv @@
module lits_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lits_pkg::status_t status_i,
  output lits_pkg::cmd_t    cmd_o
);

  lits_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lits_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      lits_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lits_pkg::ST_START;
        end
      end
      lits_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.pass_none ? lits_pkg::ST_DONE : lits_pkg::ST_ISSUE;
      end
      lits_pkg::ST_ISSUE: begin
        if (status_i.walk_end) begin
          state_d = lits_pkg::ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          state_d     = lits_pkg::ST_EVAL;
        end
      end
      lits_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        priority if (status_i.eval_stop) begin
          state_d = lits_pkg::ST_DONE;
        end else if (status_i.eval_stay) begin
          state_d = lits_pkg::ST_EVAL;
        end else begin
          state_d = lits_pkg::ST_ISSUE;
        end
      end
      lits_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = status_i.next_pass ? lits_pkg::ST_START : lits_pkg::ST_DONE;
      end
      lits_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          state_d        = lits_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lits_pkg::ST_IDLE;
      end
    endcase
  end

  a_eval_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lits_pkg::ST_EVAL |->
      $past(state_q) == lits_pkg::ST_ISSUE || $past(state_q) == lits_pkg::ST_EVAL)
    else $error("eval without a preceding read");

endmodule

@@ sv/lits_dp.sv @@
module lits_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lits_pkg::cmd_t             cmd_i,
  output lits_pkg::status_t          status_o,
  input  logic [2:0]                 opcode_i,
  input  logic [31:0]                start_line_i,
  input  logic [31:0]                end_line_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic                       covered_o,
  output logic                       overflow_o,
  output logic [4:0]                 valid_entries_o,
  output logic [4:0]                 invalid_entries_o
);

  lits_pkg::opcode_e op_q;
  lits_pkg::pass_e   pass_q;
  lits_pkg::line_t   s_q, e_q, reach_q;
  lits_pkg::cnt_t    i_q, n_q;
  lits_pkg::cnt_t    cnt_q [2];
  logic [1:0]        bank_q;
  logic              tbl_q, phase_q, placed_q, cov_q, ovf_q;
  logic              out_valid_q, out_cov_q, out_ovf_q;
  logic [4:0]        out_vcnt_q, out_icnt_q;

  logic [lits_pkg::RAM_W-1:0] rdata;
  lits_pkg::line_t            rd_a, rd_b;
  lits_pkg::addr_t            raddr, waddr;
  logic                       ram_we;
  logic [lits_pkg::RAM_W-1:0] wdata;

  logic            emit_req, stay, stop_now, adv, full, fin_emit, merge, reach_upd;
  logic            start_none;
  lits_pkg::line_t emit_s, emit_e;

  assign rd_a  = rdata[lits_pkg::RAM_W-1:lits_pkg::LINE_BITS];
  assign rd_b  = rdata[lits_pkg::LINE_BITS-1:0];
  assign full  = (n_q == lits_pkg::CNT_MAX);
  assign fin_emit = (pass_q == lits_pkg::PASS_INS) && !placed_q;

  // per-entry decision
  always_comb begin
    emit_req  = 1'b0;
    emit_s    = rd_a;
    emit_e    = rd_b;
    stay      = 1'b0;
    stop_now  = 1'b0;
    adv       = 1'b1;
    merge     = 1'b0;
    reach_upd = 1'b0;
    unique case (pass_q)
      lits_pkg::PASS_INS: begin
        if (rd_b < s_q) begin
          emit_req = 1'b1;
        end else if (rd_a > e_q) begin
          emit_req = 1'b1;
          if (!placed_q) begin
            emit_s = s_q;
            emit_e = e_q;
            stay   = 1'b1;
            adv    = 1'b0;
          end
        end else begin
          merge = 1'b1;
        end
      end
      lits_pkg::PASS_CUT: begin
        if (rd_b <= s_q) begin
          emit_req = 1'b1;
        end else if (rd_a < s_q) begin
          emit_req = 1'b1;
          emit_e   = s_q;
        end
      end
      lits_pkg::PASS_QRY: begin
        if (rd_b > reach_q) begin
          if (rd_a > reach_q) begin
            stop_now = 1'b1;
          end else begin
            reach_upd = 1'b1;
            stop_now  = (rd_b >= e_q);
          end
        end
      end
      default: begin
        adv = 1'b1;
      end
    endcase
    if (emit_req && full) begin
      stop_now = 1'b1;
    end
  end

  always_comb begin
    start_none = 1'b1;
    if (phase_q) begin
      start_none = (s_q == lits_pkg::LINE_MAX);
    end else begin
      unique case (op_q)
        lits_pkg::OP_ADD_VALID,
        lits_pkg::OP_ADD_INVALID,
        lits_pkg::OP_QUERY:      start_none = (e_q <= s_q);
        lits_pkg::OP_INVALIDATE: start_none = 1'b0;
        default:                 start_none = 1'b1;
      endcase
    end
  end

  assign status_o.pass_none = start_none;
  assign status_o.walk_end  = (i_q == cnt_q[tbl_q]);
  assign status_o.eval_stay = stay && !full;
  assign status_o.eval_stop = stop_now;
  assign status_o.next_pass = (pass_q == lits_pkg::PASS_CUT);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign raddr = {tbl_q, bank_q[tbl_q], i_q[lits_pkg::IDX_W-1:0]};
  assign waddr = {tbl_q, ~bank_q[tbl_q], n_q[lits_pkg::IDX_W-1:0]};
  assign ram_we = !full && ((cmd_i.eval && emit_req) || (cmd_i.finish && fin_emit));
  assign wdata  = cmd_i.finish ? {s_q, e_q} : {emit_s, emit_e};

  lits_ram #(
    .WIDTH(lits_pkg::RAM_W),
    .DEPTH(lits_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // table counts, bank selects and the result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      bank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start && !phase_q) begin
        if (op_q == lits_pkg::OP_CLR_VALID || op_q == lits_pkg::OP_CLR_ALL) begin
          cnt_q[0] <= '0;
        end
        if (op_q == lits_pkg::OP_CLR_INVALID || op_q == lits_pkg::OP_CLR_ALL) begin
          cnt_q[1] <= '0;
        end
      end
      if (cmd_i.finish && pass_q != lits_pkg::PASS_QRY && !(fin_emit && full)) begin
        bank_q[tbl_q] <= ~bank_q[tbl_q];
        cnt_q[tbl_q]  <= n_q + lits_pkg::cnt_t'(fin_emit);
      end
      if (cmd_i.emit_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= lits_pkg::opcode_e'(opcode_i);
      s_q     <= lits_pkg::line_t'(start_line_i);
      e_q     <= lits_pkg::line_t'(end_line_i);
      phase_q <= 1'b0;
      cov_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end
    if (cmd_i.start) begin
      i_q      <= '0;
      n_q      <= '0;
      placed_q <= 1'b0;
      reach_q  <= s_q;
      if (phase_q) begin
        e_q    <= lits_pkg::LINE_MAX;
        tbl_q  <= lits_pkg::TBL_INVALID;
        pass_q <= lits_pkg::PASS_INS;
      end else begin
        unique case (op_q)
          lits_pkg::OP_ADD_INVALID: begin
            tbl_q  <= lits_pkg::TBL_INVALID;
            pass_q <= lits_pkg::PASS_INS;
          end
          lits_pkg::OP_INVALIDATE: begin
            tbl_q  <= lits_pkg::TBL_VALID;
            pass_q <= lits_pkg::PASS_CUT;
          end
          lits_pkg::OP_QUERY: begin
            tbl_q  <= lits_pkg::TBL_VALID;
            pass_q <= lits_pkg::PASS_QRY;
            cov_q  <= (e_q <= s_q);
          end
          default: begin
            tbl_q  <= lits_pkg::TBL_VALID;
            pass_q <= lits_pkg::PASS_INS;
          end
        endcase
      end
    end
    if (cmd_i.eval) begin
      if (emit_req && full) begin
        ovf_q <= 1'b1;
      end else if (emit_req) begin
        n_q <= n_q + lits_pkg::cnt_t'(1);
      end
      if (stay) begin
        placed_q <= 1'b1;
      end
      if (adv) begin
        i_q <= i_q + lits_pkg::cnt_t'(1);
      end
      if (merge) begin
        if (rd_a < s_q) begin
          s_q <= rd_a;
        end
        if (rd_b > e_q) begin
          e_q <= rd_b;
        end
      end
      if (reach_upd) begin
        reach_q <= rd_b;
      end
      if (pass_q == lits_pkg::PASS_QRY && stop_now) begin
        cov_q <= reach_upd;
      end
    end
    if (cmd_i.finish) begin
      if (pass_q == lits_pkg::PASS_QRY) begin
        cov_q <= (reach_q >= e_q);
      end
      if (fin_emit && full) begin
        ovf_q <= 1'b1;
      end
      if (pass_q == lits_pkg::PASS_CUT) begin
        phase_q <= 1'b1;
      end
    end
    if (cmd_i.emit_out) begin
      out_cov_q  <= cov_q;
      out_ovf_q  <= ovf_q;
      out_vcnt_q <= 5'(cnt_q[0]);
      out_icnt_q <= 5'(cnt_q[1]);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign covered_o         = out_cov_q;
  assign overflow_o        = out_ovf_q;
  assign valid_entries_o   = out_vcnt_q;
  assign invalid_entries_o = out_icnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= lits_pkg::CNT_MAX && cnt_q[1] <= lits_pkg::CNT_MAX)
    else $error("table count beyond depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> n_q < lits_pkg::CNT_MAX)
    else $error("write past table depth");

  a_query_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && pass_q == lits_pkg::PASS_QRY |-> !ovf_q)
    else $error("overflow raised by a query");

endmodule

@@ sv/line_interval_set_tracker_core.sv @@
// each request walks its table entry by entry; clears and empty add or query intervals walk no
// table; invalidate walks the valid table and then the invalid table
// one request at a time: a new one is not accepted until the last result enters the output
// slot; the table ram has a single read port and a registered read
// reset: both entry counts clear to zero, table contents are left undefined
module line_interval_set_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] start_line_i,
  input  logic [31:0] end_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        covered_o,
  output logic        overflow_o,
  output logic [4:0]  valid_entries_o,
  output logic [4:0]  invalid_entries_o
);

  lits_pkg::cmd_t    cmd;
  lits_pkg::status_t status;

  lits_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lits_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .start_line_i     (start_line_i),
    .end_line_i       (end_line_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .covered_o        (covered_o),
    .overflow_o       (overflow_o),
    .valid_entries_o  (valid_entries_o),
    .invalid_entries_o(invalid_entries_o)
  );

endmodule
